FILE: rtl/ebvm_pkg.sv
// ebvm_pkg: shared types, codes and small functions of the 8-bit vm execute core
// no dependencies
`default_nettype none
package ebvm_pkg;

  localparam int RAM_AW     = 12;
  localparam int RAM_BYTES  = 4096;
  localparam int ROW_AW     = 5;
  localparam int SCR_COLS   = 64;
  localparam int FONT_BYTES = 80;

  // input modes
  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_EXEC = 3'd1;
  localparam logic [2:0] MODE_TICK = 3'd2;
  localparam logic [2:0] MODE_KEY  = 3'd3;
  localparam logic [2:0] MODE_ROW  = 3'd4;
  localparam logic [2:0] MODE_BYTE = 3'd5;

  // opcode groups (top nibble)
  localparam logic [3:0] OPG_SYS   = 4'h0;
  localparam logic [3:0] OPG_JP    = 4'h1;
  localparam logic [3:0] OPG_CALL  = 4'h2;
  localparam logic [3:0] OPG_SEQI  = 4'h3;
  localparam logic [3:0] OPG_SNEI  = 4'h4;
  localparam logic [3:0] OPG_SEQR  = 4'h5;
  localparam logic [3:0] OPG_LDI   = 4'h6;
  localparam logic [3:0] OPG_ADDI  = 4'h7;
  localparam logic [3:0] OPG_ALU   = 4'h8;
  localparam logic [3:0] OPG_SNER  = 4'h9;
  localparam logic [3:0] OPG_LDIDX = 4'hA;
  localparam logic [3:0] OPG_RND   = 4'hC;
  localparam logic [3:0] OPG_DRW   = 4'hD;
  localparam logic [3:0] OPG_KEY   = 4'hE;
  localparam logic [3:0] OPG_MISC  = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_PRESSED  = 8'h9E;
  localparam logic [7:0] KEY_RELEASED = 8'hA1;

  localparam logic [7:0] F_GETDT = 8'h07;
  localparam logic [7:0] F_WAITK = 8'h0A;
  localparam logic [7:0] F_SETDT = 8'h15;
  localparam logic [7:0] F_SETST = 8'h18;
  localparam logic [7:0] F_ADDI  = 8'h1E;
  localparam logic [7:0] F_FONT  = 8'h29;
  localparam logic [7:0] F_BCD   = 8'h33;
  localparam logic [7:0] F_STORE = 8'h55;
  localparam logic [7:0] F_LOAD  = 8'h65;

  localparam logic [4:0] NO_KEY = 5'h10;
  localparam logic [3:0] VF_IDX = 4'hF;

  typedef enum logic [2:0] {
    KIND_LOAD, KIND_EXEC, KIND_TICK, KIND_KEY, KIND_ROW, KIND_BYTE, KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] address;
    logic [7:0]  data;
    logic [3:0]  key_index;
    logic        key_down;
    logic [7:0]  random_byte;
  } item_t;

  typedef struct packed {
    logic        stack_fault;
    logic        bad_opcode;
    logic        waiting_for_key;
    logic        sound_on;
    logic [63:0] read_data;
    logic [11:0] pc;
  } result_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MEM_CAP, S_FETCH0, S_FETCH1, S_FETCH2, S_READ_VY, S_EXEC,
    S_WR_VF, S_RET, S_CLS, S_DRAW_RD, S_DRAW_WR, S_BCD, S_STORE_RD, S_STORE_WR,
    S_LOAD_RD, S_LOAD_WR, S_DONE
  } state_t;

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // font byte for an address, zero above the font
  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (a < 12'(FONT_BYTES)) b = FONT_ROM[a[6:0]];
    return b;
  endfunction

  // hundreds, tens, ones of a byte by reciprocal multiplication
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [15:0] ph;
    logic [15:0] pt;
    logic [7:0]  h;
    logic [7:0]  rem;
    logic [7:0]  t;
    logic [7:0]  o;
    ph  = 16'(v) * 16'd41;
    h   = 8'(ph >> 12);
    rem = v - 8'(16'(h) * 16'd100);
    pt  = 16'(rem) * 16'd205;
    t   = 8'(pt >> 11);
    o   = rem - 8'(16'(t) * 16'd10);
    return {h[3:0], t[3:0], o[3:0]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ebvm_front.sv
// ebvm_front: input stage, classifies each item by mode and queues it
// depends on ebvm_pkg
`default_nettype none
module ebvm_front
  import ebvm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_mode,
  input  wire item_t      in_item,
  output logic            q_valid,
  output item_t           q_item,
  input  wire logic       q_pop
);

  item_t      slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  kind_t      kind;
  item_t      cls_item;
  logic       push;

  always_comb begin
    unique case (in_mode)
      MODE_LOAD: kind = KIND_LOAD;
      MODE_EXEC: kind = KIND_EXEC;
      MODE_TICK: kind = KIND_TICK;
      MODE_KEY:  kind = KIND_KEY;
      MODE_ROW:  kind = KIND_ROW;
      MODE_BYTE: kind = KIND_BYTE;
      default:   kind = KIND_NOP;
    endcase
    cls_item      = in_item;
    cls_item.kind = kind;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ (q_pop && q_valid);
    cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= cls_item;
  end

endmodule
`default_nettype wire

FILE: rtl/ebvm_back.sv
// ebvm_back: execution sequencer with memory, display, registers and return stack
// depends on ebvm_pkg
`default_nettype none
module ebvm_back
  import ebvm_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  // memories
  logic [7:0]  ram [RAM_BYTES];
  logic [63:0] disp [32];
  logic [7:0]  vreg [16];
  logic [11:0] stk [STACK_DEPTH];

  logic [11:0] ram_addr;   logic ram_we;  logic [7:0]  ram_wd;  logic [7:0]  ram_q;
  logic [4:0]  disp_addr;  logic disp_we; logic [63:0] disp_wd; logic [63:0] disp_q;
  logic [3:0]  v_addr;     logic v_we;    logic [7:0]  v_wd;    logic [7:0]  v_q;
  logic [SW-1:0] stk_addr; logic stk_we;  logic [11:0] stk_wd;  logic [11:0] stk_q;

  always_ff @(posedge clk) begin
    if (ram_we) ram[ram_addr] <= ram_wd;
    ram_q <= ram[ram_addr];
  end
  always_ff @(posedge clk) begin
    if (disp_we) disp[disp_addr] <= disp_wd;
    disp_q <= disp[disp_addr];
  end
  always_ff @(posedge clk) begin
    if (v_we) vreg[v_addr] <= v_wd;
    v_q <= vreg[v_addr];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_addr] <= stk_wd;
    stk_q <= stk[stk_addr];
  end

  state_t      state_r, state_nxt;
  item_t       item_r, item_nxt;
  logic [7:0]  hi_r, hi_nxt, lo_r, lo_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        hit_r, hit_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [11:0] bcd_r, bcd_nxt;
  logic [63:0] rd_r, rd_nxt;
  logic        bad_r, bad_nxt, fault_r, fault_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] i_r, i_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [7:0]  dt_r, dt_nxt, st_r, st_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic        wait_r, wait_nxt;
  logic [4:0]  rkey_r, rkey_nxt;
  logic [11:0] clr_r, clr_nxt;
  logic        ov_r, ov_nxt;
  result_t     res_r, res_nxt;

  logic [15:0] op;
  logic [3:0]  x, n;
  logic [11:0] pc2, pc4, nnn;
  logic [8:0]  sum9;
  logic [5:0]  row;
  logic [63:0] bits;
  logic        res_free;

  assign res_valid = ov_r;
  assign res       = res_r;
  assign res_free  = !ov_r || res_ready;

  always_comb begin
    state_nxt = state_r; item_nxt = item_r; hi_nxt = hi_r; lo_nxt = lo_r;
    vx_nxt = vx_r; vy_nxt = vy_r; cnt_nxt = cnt_r; hit_nxt = hit_r; flag_nxt = flag_r;
    bcd_nxt = bcd_r; rd_nxt = rd_r; bad_nxt = bad_r; fault_nxt = fault_r;
    pc_nxt = pc_r; i_nxt = i_r; sp_nxt = sp_r; dt_nxt = dt_r; st_nxt = st_r;
    keys_nxt = keys_r; wait_nxt = wait_r; rkey_nxt = rkey_r; clr_nxt = clr_r;
    ov_nxt = ov_r && !res_ready; res_nxt = res_r;
    q_pop = 1'b0;
    ram_addr = pc_r; ram_we = 1'b0; ram_wd = 8'h00;
    disp_addr = item_r.address[4:0]; disp_we = 1'b0; disp_wd = '0;
    v_addr = hi_r[3:0]; v_we = 1'b0; v_wd = 8'h00;
    stk_addr = sp_r[SW-1:0]; stk_we = 1'b0; stk_wd = pc_r;

    op   = {hi_r, lo_r};
    x    = hi_r[3:0];
    n    = lo_r[3:0];
    nnn  = {hi_r[3:0], lo_r};
    pc2  = pc_r + 12'd2;
    pc4  = pc_r + 12'd4;
    sum9 = 9'(vx_r) + 9'(v_q);
    row  = {1'b0, vy_r[4:0]} + {2'b00, cnt_r};
    bits = {ram_q, 56'b0} >> vx_r[5:0];

    unique case (state_r)
      S_INIT: begin
        // clearing pass: font into low memory, zeros elsewhere
        ram_addr = clr_r; ram_we = 1'b1; ram_wd = font_byte(clr_r);
        disp_addr = clr_r[4:0]; disp_we = (clr_r < 12'd32);
        v_addr = clr_r[3:0]; v_we = (clr_r < 12'd16);
        clr_nxt = clr_r + 12'd1;
        if (clr_r == 12'(RAM_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1; item_nxt = q_item;
          bad_nxt = 1'b0; fault_nxt = 1'b0; rd_nxt = '0;
          unique case (q_item.kind)
            KIND_LOAD: begin
              ram_addr = q_item.address; ram_we = 1'b1; ram_wd = q_item.data;
              state_nxt = S_DONE;
            end
            KIND_EXEC: state_nxt = S_FETCH0;
            KIND_TICK: begin
              if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
              if (st_r != 8'd0) st_nxt = st_r - 8'd1;
              state_nxt = S_DONE;
            end
            KIND_KEY: begin
              if (q_item.key_down) keys_nxt = keys_r | (16'd1 << q_item.key_index);
              else begin
                if (wait_r) rkey_nxt = {1'b0, q_item.key_index};
                keys_nxt = keys_r & ~(16'd1 << q_item.key_index);
              end
              state_nxt = S_DONE;
            end
            KIND_ROW: begin
              disp_addr = q_item.address[4:0]; state_nxt = S_MEM_CAP;
            end
            KIND_BYTE: begin
              ram_addr = q_item.address; state_nxt = S_MEM_CAP;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_MEM_CAP: begin
        rd_nxt = (item_r.kind == KIND_ROW) ? disp_q : {56'b0, ram_q};
        state_nxt = S_DONE;
      end
      S_FETCH0: begin
        ram_addr = pc_r; state_nxt = S_FETCH1;
      end
      S_FETCH1: begin
        hi_nxt = ram_q; ram_addr = pc_r + 12'd1; state_nxt = S_FETCH2;
      end
      S_FETCH2: begin
        lo_nxt = ram_q; v_addr = hi_r[3:0]; state_nxt = S_READ_VY;
      end
      S_READ_VY: begin
        vx_nxt = v_q; v_addr = lo_r[7:4]; state_nxt = S_EXEC;
      end
      S_EXEC: begin
        vy_nxt = v_q; pc_nxt = pc2; state_nxt = S_DONE;
        v_addr = x;
        case (hi_r[7:4])
          OPG_SYS: begin
            if (op == OP_CLS) begin
              clr_nxt = 12'd0; state_nxt = S_CLS;
            end else if (op == OP_RET) begin
              if (sp_r != '0) begin
                sp_nxt = sp_r - SPW'(1); stk_addr = sp_nxt[SW-1:0]; state_nxt = S_RET;
              end else pc_nxt = 12'd0;
            end else bad_nxt = 1'b1;
          end
          OPG_JP: pc_nxt = nnn;
          OPG_CALL: begin
            if (sp_r < SPW'(STACK_DEPTH)) begin
              stk_we = 1'b1; stk_wd = pc2; sp_nxt = sp_r + SPW'(1);
            end else fault_nxt = 1'b1;
            pc_nxt = nnn;
          end
          OPG_SEQI: if (vx_r == lo_r) pc_nxt = pc4;
          OPG_SNEI: if (vx_r != lo_r) pc_nxt = pc4;
          OPG_SEQR: if (vx_r == v_q) pc_nxt = pc4;
          OPG_SNER: if (vx_r != v_q) pc_nxt = pc4;
          OPG_LDI: begin v_we = 1'b1; v_wd = lo_r; end
          OPG_ADDI: begin v_we = 1'b1; v_wd = vx_r + lo_r; end
          OPG_ALU: begin
            v_we = 1'b1;
            case (n)
              ALU_MOV: v_wd = v_q;
              ALU_OR:  v_wd = vx_r | v_q;
              ALU_AND: v_wd = vx_r & v_q;
              ALU_XOR: v_wd = vx_r ^ v_q;
              ALU_ADD: begin
                v_wd = sum9[7:0]; flag_nxt = {7'b0, sum9[8]}; state_nxt = S_WR_VF;
              end
              ALU_SUB: begin
                v_wd = vx_r - v_q; flag_nxt = {7'b0, vx_r >= v_q}; state_nxt = S_WR_VF;
              end
              ALU_SUBN: begin
                v_wd = v_q - vx_r; flag_nxt = {7'b0, v_q >= vx_r}; state_nxt = S_WR_VF;
              end
              ALU_SHR: begin
                v_wd = vx_r >> 1; flag_nxt = {7'b0, vx_r[0]}; state_nxt = S_WR_VF;
              end
              ALU_SHL: begin
                v_wd = vx_r << 1; flag_nxt = {7'b0, vx_r[7]}; state_nxt = S_WR_VF;
              end
              default: begin v_we = 1'b0; bad_nxt = 1'b1; end
            endcase
          end
          OPG_LDIDX: i_nxt = {4'b0, nnn};
          OPG_RND: begin v_we = 1'b1; v_wd = lo_r & item_r.random_byte; end
          OPG_DRW: begin
            cnt_nxt = 4'd0; hit_nxt = 1'b0;
            if (n == 4'd0) begin
              flag_nxt = 8'd0; state_nxt = S_WR_VF;
            end else state_nxt = S_DRAW_RD;
          end
          OPG_KEY: begin
            if (lo_r == KEY_PRESSED) begin
              if (vx_r[7:4] == 4'd0 && keys_r[vx_r[3:0]]) pc_nxt = pc4;
            end else if (lo_r == KEY_RELEASED) begin
              if (vx_r[7:4] == 4'd0 && !keys_r[vx_r[3:0]]) pc_nxt = pc4;
            end else bad_nxt = 1'b1;
          end
          OPG_MISC: begin
            case (lo_r)
              F_GETDT: begin v_we = 1'b1; v_wd = dt_r; end
              F_SETDT: dt_nxt = vx_r;
              F_SETST: st_nxt = vx_r;
              F_ADDI:  i_nxt = i_r + 16'(vx_r);
              F_WAITK: begin
                if (wait_r && !rkey_r[4]) begin
                  v_we = 1'b1; v_wd = {4'b0, rkey_r[3:0]};
                  rkey_nxt = NO_KEY; wait_nxt = 1'b0;
                end else begin
                  wait_nxt = 1'b1; pc_nxt = pc_r;
                end
              end
              F_FONT: i_nxt = 16'({vx_r[3:0], 2'b00}) + 16'(vx_r[3:0]);
              F_BCD: begin
                bcd_nxt = bcd_digits(vx_r); cnt_nxt = 4'd0; state_nxt = S_BCD;
              end
              F_STORE: begin cnt_nxt = 4'd0; state_nxt = S_STORE_RD; end
              F_LOAD:  begin cnt_nxt = 4'd0; state_nxt = S_LOAD_RD; end
              default: bad_nxt = 1'b1;
            endcase
          end
          default: bad_nxt = 1'b1;
        endcase
      end
      S_WR_VF: begin
        v_addr = VF_IDX; v_we = 1'b1; v_wd = flag_r; state_nxt = S_DONE;
      end
      S_RET: begin
        pc_nxt = stk_q; state_nxt = S_DONE;
      end
      S_CLS: begin
        disp_addr = clr_r[4:0]; disp_we = 1'b1; disp_wd = '0;
        clr_nxt = clr_r + 12'd1;
        if (clr_r[4:0] == 5'd31) state_nxt = S_DONE;
      end
      S_DRAW_RD: begin
        if (row[5]) begin
          flag_nxt = {7'b0, hit_r}; state_nxt = S_WR_VF;
        end else begin
          ram_addr = i_r[11:0] + 12'(cnt_r); disp_addr = row[4:0];
          state_nxt = S_DRAW_WR;
        end
      end
      S_DRAW_WR: begin
        disp_addr = row[4:0]; disp_we = 1'b1; disp_wd = disp_q ^ bits;
        hit_nxt = hit_r | (|(disp_q & bits));
        if (cnt_r == n - 4'd1) begin
          flag_nxt = {7'b0, hit_nxt}; state_nxt = S_WR_VF;
        end else begin
          cnt_nxt = cnt_r + 4'd1; state_nxt = S_DRAW_RD;
        end
      end
      S_BCD: begin
        ram_addr = i_r[11:0] + 12'(cnt_r); ram_we = 1'b1;
        case (cnt_r[1:0])
          2'd0:    ram_wd = {4'b0, bcd_r[11:8]};
          2'd1:    ram_wd = {4'b0, bcd_r[7:4]};
          default: ram_wd = {4'b0, bcd_r[3:0]};
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd2) state_nxt = S_DONE;
      end
      S_STORE_RD: begin
        v_addr = cnt_r; state_nxt = S_STORE_WR;
      end
      S_STORE_WR: begin
        ram_addr = i_r[11:0] + 12'(cnt_r); ram_we = 1'b1; ram_wd = v_q;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = (cnt_r == x) ? S_DONE : S_STORE_RD;
      end
      S_LOAD_RD: begin
        ram_addr = i_r[11:0] + 12'(cnt_r); state_nxt = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        v_addr = cnt_r; v_we = 1'b1; v_wd = ram_q;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = (cnt_r == x) ? S_DONE : S_LOAD_RD;
      end
      S_DONE: begin
        if (res_free) begin
          ov_nxt = 1'b1;
          res_nxt.pc = pc_r;
          res_nxt.read_data = rd_r;
          res_nxt.sound_on = (st_r != 8'd0);
          res_nxt.waiting_for_key = wait_r;
          res_nxt.bad_opcode = bad_r;
          res_nxt.stack_fault = fault_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= 12'd0;
      pc_r    <= 12'h200;
      i_r     <= 16'd0;
      sp_r    <= '0;
      dt_r    <= 8'd0;
      st_r    <= 8'd0;
      keys_r  <= 16'd0;
      wait_r  <= 1'b0;
      rkey_r  <= NO_KEY;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      i_r     <= i_nxt;
      sp_r    <= sp_nxt;
      dt_r    <= dt_nxt;
      st_r    <= st_nxt;
      keys_r  <= keys_nxt;
      wait_r  <= wait_nxt;
      rkey_r  <= rkey_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; hi_r <= hi_nxt; lo_r <= lo_nxt; vx_r <= vx_nxt; vy_r <= vy_nxt;
    cnt_r <= cnt_nxt; hit_r <= hit_nxt; flag_r <= flag_nxt; bcd_r <= bcd_nxt;
    rd_r <= rd_nxt; bad_r <= bad_nxt; fault_r <= fault_nxt; res_r <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/eight_bit_vm_execute_core.sv
// eight_bit_vm_execute_core: top level of the 8-bit vm execute core
// depends on ebvm_pkg, ebvm_front, ebvm_back
//
//   channel | ports          | tdata / tuser contents
//   input   | in_t*          | tuser: mode; tdata: address, data, key_index, key_down, random
//   result  | out_t*         | tdata: pc, read_data, sound_on, waiting, bad_opcode, stack_fault
//
// items are handled one at a time by the back's state sequence: an execute fetches
// both opcode bytes and reads the registers, a screen clear writes all 32 display rows,
// a draw reads and writes each sprite row, stopping at the bottom edge, and a block
// store or load moves one register at a time; memory has a single port
// after reset a clearing pass writes the font and zeros memory,
// display and registers; items queue in the front meanwhile
// a two-entry queue parts intake from execution; a result register holds one
// finished result, so the back stalls only when it and the result are both full
`default_nettype none
module eight_bit_vm_execute_core
  import ebvm_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // address, data, key_index, key_down, random_byte
  input  wire logic [2:0]  in_tuser,  // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata  // pc, read_data, sound_on, waiting_for_key,
                                      // bad_opcode, stack_fault
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  // unpack the transfer; kind is filled in by the front
  always_comb begin
    in_item.kind        = KIND_NOP;
    in_item.address     = in_tdata[11:0];
    in_item.data        = in_tdata[19:12];
    in_item.key_index   = in_tdata[23:20];
    in_item.key_down    = in_tdata[24];
    in_item.random_byte = in_tdata[32:25];
  end

  ebvm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ebvm_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // result fields packed from the lowest bit up
  assign out_tdata = res;

  // no result can be pending right after reset
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a call fault and an unknown opcode come from different instructions
  a_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[79] && out_tdata[78]))
    else $error("stack fault and bad opcode together");

endmodule
`default_nettype wire

FILE: test/ebvm_checker.sv
// ebvm_checker: watches both streams of the vm execute core, predicts each result
// depends on ebvm_pkg
`timescale 1ns / 1ps
module ebvm_checker
  import ebvm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,   // address, data, key_index, key_down, random_byte
  input  wire logic [2:0]  in_tuser,   // mode
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [79:0] out_tdata,  // pc, read_data, sound_on, waiting_for_key,
                                       // bad_opcode, stack_fault
  output int               errors,
  output int               pending,
  output logic [11:0]      model_pc
);

  logic [7:0]  ram [RAM_BYTES];
  logic [63:0] rows [32];
  logic [7:0]  vreg [16];
  logic [15:0] iptr;
  logic [11:0] pcr;
  logic [11:0] rstack [16];
  int          depth;
  logic [7:0]  dly;
  logic [7:0]  snd;
  logic [15:0] keys;
  logic        armed;
  logic [4:0]  relkey;
  result_t     expected_results [$];
  int          fail_cnt;

  assign errors   = fail_cnt;
  assign pending  = expected_results.size();
  assign model_pc = pcr;

  task automatic vm_reset();
    for (int a = 0; a < RAM_BYTES; a++) ram[a] = (a < FONT_BYTES) ? FONT_ROM[a] : 8'h00;
    for (int r = 0; r < 32; r++) rows[r] = '0;
    for (int r = 0; r < 16; r++) vreg[r] = '0;
    iptr = '0; pcr = 12'h200; depth = 0; dly = '0; snd = '0; keys = '0;
    armed = 1'b0; relkey = NO_KEY;
  endtask

  task automatic run_instr(input logic [7:0] rnd, output logic bad, output logic fault);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, a;
    logic [8:0]  sum;
    logic [63:0] bits;
    logic [7:0]  hit;
    int          col, top;
    bad = 1'b0; fault = 1'b0;
    op  = {ram[pcr], ram[pcr + 12'd1]};
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
    vx = vreg[x]; vy = vreg[y];
    pcr = pcr + 12'd2;
    case (op[15:12])
      OPG_SYS: begin
        if (op == OP_CLS) begin
          for (int r = 0; r < 32; r++) rows[r] = '0;
        end else if (op == OP_RET) begin
          if (depth > 0) begin
            depth--;
            pcr = rstack[depth];
          end else pcr = 12'h000;
        end else bad = 1'b1;
      end
      OPG_JP: pcr = nnn;
      OPG_CALL: begin
        if (depth < 16) begin
          rstack[depth] = pcr;
          depth++;
        end else fault = 1'b1;
        pcr = nnn;
      end
      OPG_SEQI: if (vx == nn) pcr = pcr + 12'd2;
      OPG_SNEI: if (vx != nn) pcr = pcr + 12'd2;
      OPG_SEQR: if (vx == vy) pcr = pcr + 12'd2;
      OPG_SNER: if (vx != vy) pcr = pcr + 12'd2;
      OPG_LDI:  vreg[x] = nn;
      OPG_ADDI: vreg[x] = vx + nn;
      OPG_ALU: begin
        case (n)
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vreg[x] = sum[7:0];
            vreg[VF_IDX] = {7'h0, sum[8]};
          end
          ALU_SUB: begin
            vreg[x] = vx - vy;
            vreg[VF_IDX] = {7'h0, vx >= vy};
          end
          ALU_SUBN: begin
            vreg[x] = vy - vx;
            vreg[VF_IDX] = {7'h0, vy >= vx};
          end
          ALU_SHR: begin
            vreg[x] = vx >> 1;
            vreg[VF_IDX] = {7'h0, vx[0]};
          end
          ALU_SHL: begin
            vreg[x] = vx << 1;
            vreg[VF_IDX] = {7'h0, vx[7]};
          end
          default: bad = 1'b1;
        endcase
      end
      OPG_LDIDX: iptr = {4'h0, nnn};
      OPG_RND:   vreg[x] = nn & rnd;
      OPG_DRW: begin
        // xor sprite rows in, clipped at the right and bottom edges
        col = vx % 64; top = vy % 32; hit = 8'h00;
        for (int r = 0; r < n; r++) begin
          if (top + r >= 32) break;
          a    = iptr[11:0] + 12'(r);
          bits = {ram[a], 56'h0} >> col;
          if ((rows[top + r] & bits) != 0) hit = 8'h01;
          rows[top + r] ^= bits;
        end
        vreg[VF_IDX] = hit;
      end
      OPG_KEY: begin
        if (nn == KEY_PRESSED) begin
          if (vx <= 8'd15 && keys[vx[3:0]]) pcr = pcr + 12'd2;
        end else if (nn == KEY_RELEASED) begin
          if (vx <= 8'd15 && !keys[vx[3:0]]) pcr = pcr + 12'd2;
        end else bad = 1'b1;
      end
      OPG_MISC: begin
        a = iptr[11:0];
        case (nn)
          F_GETDT: vreg[x] = dly;
          F_SETDT: dly = vx;
          F_SETST: snd = vx;
          F_ADDI:  iptr = iptr + {8'h0, vx};
          F_WAITK: begin
            if (armed && !relkey[4]) begin
              vreg[x] = {4'h0, relkey[3:0]};
              relkey  = NO_KEY;
              armed   = 1'b0;
            end else begin
              armed = 1'b1;
              pcr   = pcr - 12'd2;
            end
          end
          F_FONT: iptr = {12'h0, vx[3:0]} * 16'd5;
          F_BCD: begin
            ram[a]         = vx / 100;
            ram[a + 12'd1] = (vx / 10) % 10;
            ram[a + 12'd2] = vx % 10;
          end
          F_STORE: for (int i = 0; i <= x; i++) ram[a + 12'(i)] = vreg[i];
          F_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = ram[a + 12'(i)];
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;  // jump with offset is not supported
    endcase
  endtask

  task automatic predict_item(input logic [2:0] mode, input logic [39:0] d,
                              output result_t res);
    logic [11:0] addr;
    logic [3:0]  key;
    logic        bad, fault;
    addr = d[11:0]; key = d[23:20];
    bad = 1'b0; fault = 1'b0;
    res = '0;
    case (mode)
      MODE_LOAD: ram[addr] = d[19:12];
      MODE_EXEC: run_instr(d[32:25], bad, fault);
      MODE_TICK: begin
        if (dly != 0) dly--;
        if (snd != 0) snd--;
      end
      MODE_KEY: begin
        if (d[24]) keys[key] = 1'b1;
        else begin
          if (armed) relkey = {1'b0, key};
          keys[key] = 1'b0;
        end
      end
      MODE_ROW:  res.read_data = rows[addr[4:0]];
      MODE_BYTE: res.read_data = {56'h0, ram[addr]};
      default: ;
    endcase
    res.pc              = pcr;
    res.sound_on        = (snd != 0);
    res.waiting_for_key = armed;
    res.bad_opcode      = bad;
    res.stack_fault     = fault;
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      vm_reset();
      expected_results.delete();
      fail_cnt = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item(in_tuser, in_tdata, want);
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_tdata);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got.pc != want.pc) begin
            $error("pc: expected %h, actual %h", want.pc, got.pc); fail_cnt++;
          end
          if (got.read_data != want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
            fail_cnt++;
          end
          if (got.sound_on != want.sound_on) begin
            $error("sound_on: expected %b, actual %b", want.sound_on, got.sound_on);
            fail_cnt++;
          end
          if (got.waiting_for_key != want.waiting_for_key) begin
            $error("waiting_for_key: expected %b, actual %b", want.waiting_for_key,
                   got.waiting_for_key);
            fail_cnt++;
          end
          if (got.bad_opcode != want.bad_opcode) begin
            $error("bad_opcode: expected %b, actual %b", want.bad_opcode, got.bad_opcode);
            fail_cnt++;
          end
          if (got.stack_fault != want.stack_fault) begin
            $error("stack_fault: expected %b, actual %b", want.stack_fault,
                   got.stack_fault);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
// tb: stimulus and verdict for the 8-bit vm execute core
// depends on ebvm_pkg, eight_bit_vm_execute_core, ebvm_checker
`timescale 1ns / 1ps
module tb;
  import ebvm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL   = 1800;
  localparam int CALM_AFTER  = 1500;  // no idling past this many items

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // address, data, key_index, key_down, random_byte
  logic [2:0]  in_tuser = '0;   // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // pc, read_data, sound_on, waiting_for_key,
                                // bad_opcode, stack_fault
  int          errors;
  int          pending;
  logic [11:0] model_pc;
  int          items_sent = 0;
  int          cycles = 0;
  logic        random_phase = 1'b0;

  always #1 clk = ~clk;

  eight_bit_vm_execute_core uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  ebvm_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .errors, .pending, .model_pc
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off once the random part starts
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (random_phase && !held) begin
        // long hold-off so the core fills up and drops in_tready
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (items_sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // one item transfer; valid stays high between back-to-back items
  task automatic send(input logic [2:0] mode, input logic [11:0] addr,
                      input logic [7:0] data, input logic [3:0] key,
                      input logic down, input logic [7:0] rnd);
    if (items_sent < CALM_AFTER && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'h0, rnd, down, key, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // random key_index, key_down and random_byte fields for an item
  task automatic send_mode(input logic [2:0] mode, input logic [11:0] addr,
                           input logic [7:0] data);
    send(mode, addr, data, 4'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic load_op(input logic [11:0] addr, input logic [15:0] op);
    send_mode(MODE_LOAD, addr, op[15:8]);
    send_mode(MODE_LOAD, addr + 12'd1, op[7:0]);
  endtask

  task automatic step();
    send_mode(MODE_EXEC, 12'($urandom), 8'($urandom));
  endtask

  // let every expected result arrive so the predicted pc is settled
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic jump_to(input logic [11:0] target);
    logic [11:0] here;
    drain();
    here = model_pc;
    load_op(here, {OPG_JP, target});
    step();
  endtask

  // random instruction, weighted toward the recognized forms
  function automatic logic [15:0] pick_op();
    logic [3:0]  g, x, y;
    logic [15:0] op;
    logic [7:0]  f_codes [10];
    logic [3:0]  alu_codes [9];
    f_codes   = '{F_GETDT, F_WAITK, F_SETDT, F_SETST, F_ADDI, F_FONT, F_BCD,
                  F_STORE, F_LOAD, F_WAITK};
    alu_codes = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                  ALU_SUBN, ALU_SHL};
    g  = 4'($urandom);
    x  = 4'($urandom);
    y  = 4'($urandom);
    op = {g, 12'($urandom)};
    case (g)
      OPG_SYS: case ($urandom_range(0, 2))
        0: op = OP_CLS;
        1: op = OP_RET;
        default: ;
      endcase
      OPG_ALU:
        if ($urandom_range(0, 7) != 0) op = {g, x, y, alu_codes[$urandom_range(0, 8)]};
      OPG_KEY: case ($urandom_range(0, 2))
        0: op = {g, x, KEY_PRESSED};
        1: op = {g, x, KEY_RELEASED};
        default: ;
      endcase
      OPG_MISC:
        if ($urandom_range(0, 7) != 0) op = {g, x, f_codes[$urandom_range(0, 9)]};
      default: ;
    endcase
    // keep registers loaded with varied values
    if ($urandom_range(0, 5) == 0) op = {OPG_LDI, x, 8'($urandom)};
    return op;
  endfunction

  // fill the stack past its depth, then unwind past empty
  task automatic stack_run();
    logic [11:0] base;
    base = 12'($urandom_range(12'h300, 12'hE00)) & 12'hFFE;
    load_op(base, {OPG_CALL, base});
    load_op(base + 12'd2, OP_RET);
    jump_to(base);
    repeat (17) step();
    load_op(base, OP_RET);
    repeat (17) step();
  endtask

  initial begin
    logic [11:0] base;
    int          len;
    @(posedge clk);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clipped corner draw, key wait, offset jump, edge reads, idle modes
    send(MODE_LOAD, 12'h200, 8'h6F, 4'h0, 1'b0, 8'h00);
    send(MODE_LOAD, 12'h201, 8'h3F, 4'hF, 1'b1, 8'hFF);
    send(MODE_LOAD, 12'h202, 8'hDF, 4'h0, 1'b0, 8'h00);
    send(MODE_LOAD, 12'h203, 8'hF3, 4'h0, 1'b0, 8'h00);
    send(MODE_LOAD, 12'h204, 8'hF0, 4'h0, 1'b0, 8'h00);
    send(MODE_LOAD, 12'h205, F_WAITK, 4'h0, 1'b0, 8'h00);
    send(MODE_LOAD, 12'h206, 8'hB1, 4'h0, 1'b0, 8'h00);
    send(MODE_LOAD, 12'h207, 8'h23, 4'h0, 1'b0, 8'h00);
    send(MODE_EXEC, 12'h000, 8'h00, 4'h0, 1'b0, 8'hFF);
    send(MODE_EXEC, 12'hFFF, 8'hFF, 4'hF, 1'b1, 8'h00);
    send(MODE_EXEC, 12'h000, 8'h00, 4'h0, 1'b0, 8'h00);  // arms the key wait
    send(MODE_EXEC, 12'h000, 8'h00, 4'h0, 1'b0, 8'h00);  // still waiting
    send(MODE_KEY,  12'h000, 8'h00, 4'hF, 1'b1, 8'h00);
    send(MODE_KEY,  12'h000, 8'h00, 4'hF, 1'b0, 8'h00);  // release while armed
    send(MODE_EXEC, 12'h000, 8'h00, 4'h0, 1'b0, 8'h00);  // takes the key
    send(MODE_EXEC, 12'h000, 8'h00, 4'h0, 1'b0, 8'h00);  // unsupported offset jump
    send(MODE_ROW,  12'hFFF, 8'h00, 4'h0, 1'b0, 8'h00);
    send(MODE_ROW,  12'h000, 8'h00, 4'h0, 1'b0, 8'h00);
    send(MODE_BYTE, 12'hFFF, 8'h00, 4'h0, 1'b0, 8'h00);
    send(MODE_BYTE, 12'h000, 8'h00, 4'h0, 1'b0, 8'h00);
    send(MODE_TICK, 12'h000, 8'h00, 4'h0, 1'b0, 8'h00);
    send(3'd7,      12'hFFF, 8'hFF, 4'hF, 1'b1, 8'hFF);
    send(3'd6,      12'h000, 8'h00, 4'h0, 1'b0, 8'h00);
    send(MODE_LOAD, 12'hFFF, 8'hFF, 4'h0, 1'b0, 8'h00);
    send(MODE_BYTE, 12'hFFF, 8'h00, 4'h0, 1'b0, 8'h00);

    // random: short programs written to memory, entered by a jump, then run
    // with timer ticks, key events, reads and stray loads mixed in
    random_phase = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 24) == 0) stack_run();
      if ($urandom_range(0, 7) == 0) base = 12'($urandom_range(12'hFE0, 12'hFFE));
      else base = 12'($urandom_range(12'h200, 12'hE00));
      len = $urandom_range(4, 12);
      for (int k = 0; k < len; k++) load_op(base + 12'(2 * k), pick_op());
      jump_to(base);
      repeat (len + $urandom_range(0, 4)) begin
        case ($urandom_range(0, 15))
          0, 1: send_mode(MODE_TICK, 12'($urandom), 8'($urandom));
          2, 3: send_mode(MODE_KEY, 12'($urandom), 8'($urandom));
          4:    send_mode(MODE_ROW, 12'($urandom), 8'($urandom));
          5:    send_mode(MODE_BYTE, 12'($urandom), 8'($urandom));
          6:    send_mode(MODE_LOAD, 12'($urandom), 8'($urandom));
          7:    if ($urandom_range(0, 7) == 0) send_mode(3'($urandom_range(6, 7)),
                                                         12'($urandom), 8'($urandom));
                else step();
          default: step();
        endcase
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/ebvm_pkg.sv
rtl/ebvm_front.sv
rtl/ebvm_back.sv
rtl/eight_bit_vm_execute_core.sv
test/ebvm_checker.sv
test/tb.sv
